// ===== hw/rtl/spr_pkg.sv =====
// Shared types, constants and helpers for the spin-path unrank/swap-rank block.
// Used by spr_table and spin_path_unrank_and_swap_rank.
`default_nettype none

package spr_pkg;

  localparam int MAX_OPEN_SHELLS = 14;
  localparam int TDIM            = MAX_OPEN_SHELLS + 3;
  localparam int TBL_DEPTH       = TDIM * TDIM;
  localparam int ADDR_W          = $clog2(TBL_DEPTH);
  localparam int WT_W            = 11;
  localparam int COORD_W         = 6;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one table read request
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CFG = 2'd1;
  localparam logic [1:0] ST_IDX = 2'd2;
  localparam logic [1:0] ST_POS = 2'd3;

  localparam logic [1:0] REG_OPEN_SHELLS  = 2'd0;
  localparam logic [1:0] REG_MULTIPLICITY = 2'd1;
  localparam logic [1:0] REG_DICT_ORDER   = 2'd2;

  // (m, n) -> table address; entries outside the table read as zero
  function automatic rd_req_t wt_req(input coord_t m, input coord_t n);
    rd_req_t           r;
    logic [ADDR_W-1:0] mu;
    logic [ADDR_W-1:0] nu;
    mu     = ADDR_W'($unsigned(m));
    nu     = ADDR_W'($unsigned(n));
    r.ok   = (m >= 0) && (m < TDIM) && (n >= 0) && (n < TDIM);
    r.addr = r.ok ? ADDR_W'(mu * TDIM + nu) : '0;
    return r;
  endfunction

  function automatic logic cfg_ok(input logic [3:0] os, input logic [3:0] mu);
    logic [4:0] lim;
    lim = {1'b0, os} + 5'd1;
    return (int'(os) <= MAX_OPEN_SHELLS) && (mu != 4'd0) && ({1'b0, mu} <= lim) &&
           (mu[0] ^ os[0]);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spin_path_unrank_and_swap_rank.sv =====
// Top level: configuration registers and the per-request sequencer.
// Depends on spr_pkg and spr_table.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 open_shells,
//   1 multiplicity, 2 dictionary_order) and cfg_data. Every write to a
//   known register rebuilds the weight table: a sweep over all 17 * 17
//   entries, during which busy is high and start is ignored. The same sweep
//   runs after reset (open_shells 0, multiplicity 1, dictionary order).
//   Request: start is taken when busy is low; func_index and swap_position
//   are sampled then. busy stays high until the result is out.
//   Result: done is high for exactly one cycle with path_bits,
//   axial_distance, partner_index and status valid in that cycle. The
//   receiver cannot stall; results are simply presented once.
//   Flow: a bad configuration is reported from S_NF_RD, an index out of
//   range from S_NF_CHK, a bad position after the unrank walk (from
//   S_NF_CHK if open_shells is 0), else the result after the swapped-path
//   rank. Each step pairs a read state with a step state (registered reads).
//   A new request may be given in the cycle done is high.
`default_nettype none

module spin_path_unrank_and_swap_rank import spr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         func_index,
  input  logic [3:0]         swap_position,
  output logic               done,
  output logic [13:0]        path_bits,
  output logic signed [4:0]  axial_distance,
  output logic [9:0]         partner_index,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_NF_RD   = 7'b0000010,
    S_NF_CHK  = 7'b0000100,
    S_UN_RD   = 7'b0001000,
    S_UN_STEP = 7'b0010000,
    S_RK_RD   = 7'b0100000,
    S_RK_STEP = 7'b1000000
  } state_t;

  state_t state;

  logic [3:0]        os_cfg;
  logic [3:0]        mu_cfg;
  logic              dict_cfg;

  logic [9:0]        idx;
  logic [3:0]        jpos;
  logic [3:0]        cnt;
  coord_t            m;
  logic [WT_W-1:0]   test;
  logic [9:0]        rank;
  logic signed [4:0] bal;
  logic [13:0]       path;

  logic              cfg_fire;
  logic              rebuild;
  logic              cfg_good;
  logic              tbl_ready;
  rd_req_t           req_a;
  rd_req_t           req_b;
  logic [WT_W-1:0]   rdata_a;
  logic [WT_W-1:0]   rdata_b;

  logic [4:0]        k_un;
  coord_t            k_un_s;
  coord_t            un_col;
  logic [3:0]        pidx;
  logic              go_up;
  logic [13:0]       path_upd;
  logic              pos_bad;

  logic [4:0]        k_rk;
  coord_t            k_rk_s;
  logic [3:0]        bi;
  logic              s_up;
  coord_t            m_new;
  logic [9:0]        rank_new;
  logic              bj;
  logic              bj1;
  logic signed [4:0] ad;

  assign busy      = (state != S_IDLE) || !tbl_ready;
  assign cfg_ready = (state == S_IDLE) && !(start && !busy);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign rebuild   = cfg_fire && (cfg_index <= REG_DICT_ORDER);
  assign cfg_good  = cfg_ok(os_cfg, mu_cfg);

  spr_table u_table (
    .clk              (clk),
    .rst              (rst),
    .rebuild          (rebuild),
    .open_shells      (os_cfg),
    .multiplicity     (mu_cfg),
    .dictionary_order (dict_cfg),
    .cfg_good         (cfg_good),
    .rd_a             (req_a),
    .rd_b             (req_b),
    .ready            (tbl_ready),
    .rdata_a          (rdata_a),
    .rdata_b          (rdata_b)
  );

  // unrank step: dictionary order runs k upward, reverse order downward
  assign k_un   = dict_cfg ? {1'b0, cnt} + 5'd1 : {1'b0, os_cfg} - {1'b0, cnt};
  assign k_un_s = coord_t'({1'b0, k_un});
  assign un_col = dict_cfg ? k_un_s : k_un_s - coord_t'(1);
  assign pidx   = 4'(k_un - 5'd1);
  assign go_up  = (rdata_a != '0) && (test >= rdata_b);
  assign pos_bad = (jpos == 4'd0) || (jpos >= os_cfg);

  always_comb begin
    path_upd       = path;
    path_upd[pidx] = !go_up;
  end

  // rank step over the path with steps jpos and jpos+1 exchanged
  assign k_rk   = {1'b0, cnt} + 5'd1;
  assign k_rk_s = coord_t'({1'b0, k_rk});

  always_comb begin
    if (k_rk == {1'b0, jpos}) begin
      bi = jpos;
    end else if (k_rk == {1'b0, jpos} + 5'd1) begin
      bi = jpos - 4'd1;
    end else begin
      bi = 4'(k_rk - 5'd1);
    end
    s_up     = !path[bi];
    m_new    = s_up ? m + coord_t'(1) : m - coord_t'(1);
    rank_new = rank + (s_up ? rdata_a[9:0] : 10'd0);
  end

  always_comb begin
    bj  = path[jpos - 4'd1];
    bj1 = path[jpos];
    if (bj == bj1) begin
      ad = -5'sd1;
    end else if (!bj) begin
      ad = bal + 5'sd1;
    end else begin
      ad = -bal - 5'sd1;
    end
  end

  always_comb begin
    req_a = '0;
    req_b = '0;
    unique case (state)
      S_NF_RD: begin
        req_a = dict_cfg ? wt_req(coord_t'(1), coord_t'(0))
                         : wt_req(coord_t'({2'b0, mu_cfg}), coord_t'({2'b0, os_cfg}));
      end
      S_UN_RD, S_UN_STEP: begin
        req_a = wt_req(dict_cfg ? m + coord_t'(1) : m - coord_t'(1), un_col);
        req_b = wt_req(dict_cfg ? m - coord_t'(1) : m + coord_t'(1), un_col);
      end
      S_RK_RD, S_RK_STEP: begin
        req_a = dict_cfg ? wt_req(m - coord_t'(1), k_rk_s)
                         : wt_req(m + coord_t'(2), k_rk_s - coord_t'(1));
        req_b = wt_req(m_new, k_rk_s);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      os_cfg   <= 4'd0;
      mu_cfg   <= 4'd1;
      dict_cfg <= 1'b1;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_OPEN_SHELLS:  os_cfg   <= cfg_data;
          REG_MULTIPLICITY: mu_cfg   <= cfg_data;
          REG_DICT_ORDER:   dict_cfg <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start && tbl_ready) begin
            idx   <= func_index;
            jpos  <= swap_position;
            path  <= '0;
            bal   <= '0;
            state <= S_NF_RD;
          end
        end
        S_NF_RD: begin
          if (!cfg_good) begin
            path_bits      <= '0;
            axial_distance <= '0;
            partner_index  <= '0;
            status         <= ST_CFG;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_NF_CHK;
          end
        end
        S_NF_CHK: begin
          path_bits      <= '0;
          axial_distance <= '0;
          partner_index  <= '0;
          if ({1'b0, idx} >= rdata_a) begin
            status <= ST_IDX;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (os_cfg == 4'd0) begin
            status <= ST_POS;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cnt   <= '0;
            m     <= dict_cfg ? coord_t'(1) : coord_t'({2'b0, mu_cfg});
            test  <= {1'b0, idx};
            done  <= 1'b0;
            state <= S_UN_RD;
          end
        end
        S_UN_RD: begin
          done  <= 1'b0;
          state <= S_UN_STEP;
        end
        S_UN_STEP: begin
          path <= path_upd;
          if (go_up) begin
            test <= test - rdata_b;
          end
          if (k_un < {1'b0, jpos}) begin
            bal <= go_up ? bal + 5'sd1 : bal - 5'sd1;
          end
          if (cnt == os_cfg - 4'd1) begin
            if (pos_bad) begin
              path_bits <= path_upd;
              status    <= ST_POS;
              done      <= 1'b1;
              state     <= S_IDLE;
            end else begin
              cnt   <= '0;
              m     <= coord_t'(1);
              rank  <= 10'd1;
              done  <= 1'b0;
              state <= S_RK_RD;
            end
          end else begin
            // up raises the multiplicity walking right, lowers it walking left
            if (go_up == dict_cfg) begin
              m <= m + coord_t'(1);
            end else begin
              m <= m - coord_t'(1);
            end
            cnt   <= cnt + 4'd1;
            done  <= 1'b0;
            state <= S_UN_RD;
          end
        end
        S_RK_RD: begin
          done  <= 1'b0;
          state <= S_RK_STEP;
        end
        S_RK_STEP: begin
          if ((m_new <= 0) || (rdata_b == '0) || (cnt == os_cfg - 4'd1)) begin
            path_bits      <= path;
            axial_distance <= ad;
            partner_index  <= ((m_new <= 0) || (rdata_b == '0)) ? 10'd0 : rank_new;
            status         <= ST_OK;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            m     <= m_new;
            rank  <= rank_new;
            cnt   <= cnt + 4'd1;
            done  <= 1'b0;
            state <= S_RK_RD;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results in consecutive cycles");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request taken but block not busy");
  a_cfg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_CFG)) |->
      ((path_bits == '0) && (partner_index == '0) && (axial_distance == '0)))
    else $error("bad configuration result carries data");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cfg_ready) else $error("config write open during a request");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/spr_table.sv =====
// Branching-diagram weight table: memory, rebuild sweep and two read ports.
// Depends on spr_pkg.
`default_nettype none

module spr_table import spr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            rebuild,
  input  logic [3:0]      open_shells,
  input  logic [3:0]      multiplicity,
  input  logic            dictionary_order,
  input  logic            cfg_good,
  input  rd_req_t         rd_a,
  input  rd_req_t         rd_b,
  output logic            ready,
  output logic [WT_W-1:0] rdata_a,
  output logic [WT_W-1:0] rdata_b
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RD   = 3'b010,
    B_WR   = 3'b100
  } bstate_t;

  bstate_t bstate;
  logic [4:0] ci;
  logic [4:0] cj;

  logic [WT_W-1:0] mem [TBL_DEPTH];
  logic [WT_W-1:0] q_a;
  logic [WT_W-1:0] q_b;
  logic            ok_a;
  logic            ok_b;

  logic [4:0]      col;
  coord_t          pcol;
  coord_t          jrow;
  rd_req_t         bld_a;
  rd_req_t         bld_b;
  rd_req_t         sel_a;
  rd_req_t         sel_b;
  rd_req_t         wr_req;
  logic [4:0]      ns5;
  logic [4:0]      mu5;
  logic [4:0]      mdist;
  logic            seed;
  logic            rec;
  logic [WT_W-1:0] sum;
  logic [WT_W-1:0] wval;

  assign ready = (bstate == B_IDLE);

  // dictionary order walks the columns from the right end
  assign col  = dictionary_order ? 5'(TDIM - 1) - ci : ci;
  assign pcol = dictionary_order ? coord_t'({1'b0, col}) + coord_t'(1)
                                 : coord_t'({1'b0, col}) - coord_t'(1);
  assign jrow = coord_t'({1'b0, cj});

  assign bld_a  = wt_req(jrow - coord_t'(1), pcol);
  assign bld_b  = wt_req(jrow + coord_t'(1), pcol);
  assign wr_req = wt_req(jrow, coord_t'({1'b0, col}));

  assign sel_a = ready ? rd_a : bld_a;
  assign sel_b = ready ? rd_b : bld_b;

  assign rdata_a = ok_a ? q_a : '0;
  assign rdata_b = ok_b ? q_b : '0;

  always_comb begin
    ns5   = {1'b0, open_shells};
    mu5   = {1'b0, multiplicity};
    mdist = (mu5 > cj) ? mu5 - cj : cj - mu5;
    sum   = rdata_a + rdata_b;
    if (!dictionary_order) begin
      seed = (col == 5'd0) && (cj == 5'd1);
      rec  = (col >= 5'd1) && (col <= ns5) && (cj >= 5'd1) && (cj <= ns5 + 5'd1) &&
             (cj[0] != col[0]) && (mdist <= ns5 - col);
    end else begin
      seed = (col == ns5) && (cj == mu5);
      rec  = (col < ns5) && (cj >= 5'd1) && (cj <= ns5 + 5'd1) &&
             (cj[0] != col[0]) && (cj <= col + 5'd1);
    end
    if (!cfg_good) begin
      wval = '0;
    end else if (seed) begin
      wval = WT_W'(1);
    end else if (rec) begin
      wval = sum;
    end else begin
      wval = '0;
    end
  end

  always_ff @(posedge clk) begin
    ok_a <= sel_a.ok;
    ok_b <= sel_b.ok;
    q_a  <= mem[sel_a.addr];
    q_b  <= mem[sel_b.addr];
    if (bstate == B_WR) begin
      mem[wr_req.addr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      bstate <= B_RD;
      ci     <= '0;
      cj     <= '0;
    end else begin
      unique case (bstate)
        B_IDLE: ;
        B_RD:   bstate <= B_WR;
        B_WR: begin
          if (cj == 5'(TDIM - 1)) begin
            cj <= '0;
            if (ci == 5'(TDIM - 1)) begin
              bstate <= B_IDLE;
            end else begin
              ci     <= ci + 5'd1;
              bstate <= B_RD;
            end
          end else begin
            cj     <= cj + 5'd1;
            bstate <= B_RD;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rebuild_busy: assert property (@(posedge clk) disable iff (rst)
    rebuild |=> !ready) else $error("table ready right after a rebuild request");
  a_ready_holds: assert property (@(posedge clk) disable iff (rst)
    (ready && !rebuild) |=> ready) else $error("table left ready without a rebuild");
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (bstate == B_WR) |-> (wr_req.ok && (wr_req.addr < TBL_DEPTH)))
    else $error("rebuild write outside the table");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (ci < TDIM) && (cj < TDIM)) else $error("rebuild counter out of range");
`endif

endmodule

`default_nettype wire
